### rtl/core/qai_pkg.sv
// shared types and constants of the quaternion attitude integrator
`default_nettype none
package qai_pkg;

  localparam int unsigned QW = 32;
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;

  typedef struct packed {
    logic               command;
    logic signed [31:0] incr_x;
    logic signed [31:0] incr_y;
    logic signed [31:0] incr_z;
    logic signed [31:0] load_s;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
  } qai_in_t;

  typedef struct packed {
    logic signed [31:0] out_s;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               degenerate;
  } qai_out_t;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ROTATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_ACC,
    ST_SAT,
    ST_ROOT_START,
    ST_ROOT_WAIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } qai_state_t;

endpackage
`default_nettype wire

### rtl/core/qai_mul.sv
// shared signed 32x32 multiplier with registered product
`default_nettype none
module qai_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p_r
);
  logic signed [63:0] p_nxt;

  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
endmodule
`default_nettype wire

### rtl/core/qai_sqrt.sv
// iterative integer square root of a 64-bit value, one result bit per cycle
`default_nettype none
module qai_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] n,
  output logic             done_r,
  output logic [31:0]      root_r
);
  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [63:0] nsh_r;
  logic [33:0] rem_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [33:0] rem_nxt;
  logic [31:0] root_nxt;

  always_comb begin
    rem_sh   = {rem_r, nsh_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
    root_nxt = {root_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        nsh_r  <= n;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        nsh_r  <= {nsh_r[61:0], 2'b00};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/qai_div.sv
// restoring divider: round(m * 2^frac / r), one quotient bit per cycle
`default_nettype none
module qai_div #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [30:0]          m,
  input  wire logic [31:0]          r,
  output logic                      done_r,
  output logic [FRAC_BITS:0]        q_r
);
  localparam int unsigned QB    = FRAC_BITS + 1;
  localparam int unsigned NUM_W = 32 + FRAC_BITS;
  localparam int unsigned CW    = $clog2(QB + 1);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [32:0]       rem_r;
  logic [QB-1:0]     low_r;
  logic [NUM_W-1:0]  num;
  logic [32:0]       rem_sh;
  logic              ge;
  logic [32:0]       rem_nxt;

  always_comb begin
    num     = {1'b0, m, {FRAC_BITS{1'b0}}} + NUM_W'(r >> 1);
    rem_sh  = {rem_r[31:0], low_r[QB-1]};
    ge      = (rem_sh >= {1'b0, r});
    rem_nxt = ge ? 33'(rem_sh - {1'b0, r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        // high part is already below r since the quotient fits in frac+1 bits
        rem_r  <= 33'(num[NUM_W-1:QB]);
        low_r  <= num[QB-1:0];
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        low_r <= {low_r[QB-2:0], 1'b0};
        q_r   <= {q_r[QB-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(QB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/quaternion_attitude_integrator.sv
// top level: quaternion attitude integrator sequencer and state
`default_nettype none
// Keeps an attitude quaternion (identity after reset) in signed fixed point with
// FRAC_BITS fraction bits. A load beat stores the quaternion as given. A rotate
// beat adds the first-order increment using one shared 32x32 multiplier (16
// products, plus a saturation step), takes an integer square root of the norm
// squared, then divides each of the four components by it. A zero norm skips
// root and division and returns the identity with degenerate set. in_stall is
// high while a beat is in work; the result waits in an output register and a
// new beat can be taken while it is still stalled.
module quaternion_attitude_integrator #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire qai_pkg::qai_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output qai_pkg::qai_out_t    out_data
);
  import qai_pkg::*;

  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] BIAS = 64'sd1 <<< (FRAC_BITS - 2);

  qai_state_t state_r, state_nxt;

  logic signed [31:0] att_r [4];
  logic signed [31:0] t_r [4];
  logic signed [31:0] w_r [3];
  logic signed [63:0] sum_r [4];
  logic [63:0]        n_r;
  logic [3:0]         step_r;
  logic [1:0]         comp_r;
  logic               degen_r;
  logic               out_valid_r;
  qai_out_t           out_data_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [1:0]         acc_idx;
  logic               acc_neg;
  logic signed [63:0] prod4;
  logic [63:0]        n_acc;

  logic               root_start, root_done;
  logic [31:0]        root;
  logic               div_start, div_done;
  logic [FRAC_BITS:0] div_q;
  logic signed [31:0] t_cur;
  logic [30:0]        t_mag;
  logic signed [31:0] q_ext;

  logic signed [63:0] d_v [4];
  logic signed [63:0] v_v [4];
  logic signed [31:0] t_v [4];

  logic in_acc, out_free;

  qai_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  qai_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (root_start),
    .n      (n_r),
    .done_r (root_done),
    .root_r (root)
  );

  qai_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .m      (t_mag),
    .r      (root),
    .done_r (div_done),
    .q_r    (div_q)
  );

  // operand schedule: steps 0..11 are the increment products, 12..15 the squares
  always_comb begin
    mul_a   = att_r[0];
    mul_b   = w_r[0];
    acc_idx = 2'd0;
    acc_neg = 1'b0;
    case (step_r)
      4'd0:  begin mul_a = att_r[0]; mul_b = w_r[0]; acc_idx = 2'd1; acc_neg = 1'b0; end
      4'd1:  begin mul_a = att_r[2]; mul_b = w_r[2]; acc_idx = 2'd1; acc_neg = 1'b1; end
      4'd2:  begin mul_a = att_r[3]; mul_b = w_r[1]; acc_idx = 2'd1; acc_neg = 1'b0; end
      4'd3:  begin mul_a = att_r[0]; mul_b = w_r[1]; acc_idx = 2'd2; acc_neg = 1'b0; end
      4'd4:  begin mul_a = att_r[3]; mul_b = w_r[0]; acc_idx = 2'd2; acc_neg = 1'b1; end
      4'd5:  begin mul_a = att_r[1]; mul_b = w_r[2]; acc_idx = 2'd2; acc_neg = 1'b0; end
      4'd6:  begin mul_a = att_r[0]; mul_b = w_r[2]; acc_idx = 2'd3; acc_neg = 1'b0; end
      4'd7:  begin mul_a = att_r[1]; mul_b = w_r[1]; acc_idx = 2'd3; acc_neg = 1'b1; end
      4'd8:  begin mul_a = att_r[2]; mul_b = w_r[0]; acc_idx = 2'd3; acc_neg = 1'b0; end
      4'd9:  begin mul_a = att_r[1]; mul_b = w_r[0]; acc_idx = 2'd0; acc_neg = 1'b1; end
      4'd10: begin mul_a = att_r[2]; mul_b = w_r[1]; acc_idx = 2'd0; acc_neg = 1'b1; end
      4'd11: begin mul_a = att_r[3]; mul_b = w_r[2]; acc_idx = 2'd0; acc_neg = 1'b1; end
      4'd12: begin mul_a = t_r[0];   mul_b = t_r[0]; end
      4'd13: begin mul_a = t_r[1];   mul_b = t_r[1]; end
      4'd14: begin mul_a = t_r[2];   mul_b = t_r[2]; end
      4'd15: begin mul_a = t_r[3];   mul_b = t_r[3]; end
      default: begin mul_a = att_r[0]; mul_b = w_r[0]; end
    endcase
  end

  assign prod4 = mul_p >>> 2;
  assign n_acc = n_r + 64'(mul_p);

  // rounding of the increments and symmetric saturation
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_v[i] = (sum_r[i] + BIAS) >>> (FRAC_BITS - 1);
      v_v[i] = 64'(att_r[i]) + d_v[i];
      if (v_v[i] > SAT_MAX) begin
        t_v[i] = 32'(SAT_MAX);
      end else if (v_v[i] < -SAT_MAX) begin
        t_v[i] = 32'(-SAT_MAX);
      end else begin
        t_v[i] = 32'(v_v[i]);
      end
    end
  end

  assign t_cur = t_r[comp_r];
  assign t_mag = t_cur[31] ? 31'(-t_cur) : t_cur[30:0];
  assign q_ext = 32'(div_q);

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.command == CMD_ROTATE) ? ST_PROD : ST_DONE;
        end
      end
      ST_PROD: state_nxt = ST_ACC;
      ST_ACC: begin
        if (step_r == 4'd11) begin
          state_nxt = ST_SAT;
        end else if (step_r == 4'd15) begin
          state_nxt = (n_acc == 64'd0) ? ST_DONE : ST_ROOT_START;
        end else begin
          state_nxt = ST_PROD;
        end
      end
      ST_SAT:        state_nxt = ST_PROD;
      ST_ROOT_START: state_nxt = ST_ROOT_WAIT;
      ST_ROOT_WAIT:  if (root_done) state_nxt = ST_DIV_START;
      ST_DIV_START:  state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (comp_r == 2'd3) ? ST_DONE : ST_DIV_START;
        end
      end
      ST_DONE:       if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    root_start = (state_r == ST_ROOT_START);
    div_start  = (state_r == ST_DIV_START);
    out_valid  = out_valid_r;
    out_data   = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      att_r[0]    <= ONE;
      att_r[1]    <= '0;
      att_r[2]    <= '0;
      att_r[3]    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            step_r  <= '0;
            comp_r  <= '0;
            degen_r <= 1'b0;
            n_r     <= '0;
            for (int i = 0; i < 4; i++) sum_r[i] <= '0;
            w_r[0] <= in_data.incr_x;
            w_r[1] <= in_data.incr_y;
            w_r[2] <= in_data.incr_z;
            if (in_data.command == CMD_LOAD) begin
              att_r[0] <= in_data.load_s;
              att_r[1] <= in_data.load_x;
              att_r[2] <= in_data.load_y;
              att_r[3] <= in_data.load_z;
            end
          end
        end
        ST_ACC: begin
          if (step_r < 4'd12) begin
            sum_r[acc_idx] <= acc_neg ? sum_r[acc_idx] - prod4 : sum_r[acc_idx] + prod4;
          end else begin
            n_r <= n_acc;
          end
          if (step_r == 4'd15 && n_acc == 64'd0) begin
            // zero norm: fall back to the identity
            att_r[0] <= ONE;
            att_r[1] <= '0;
            att_r[2] <= '0;
            att_r[3] <= '0;
            degen_r  <= 1'b1;
          end
          if (step_r != 4'd11) begin
            step_r <= step_r + 4'd1;
          end
        end
        ST_SAT: begin
          for (int i = 0; i < 4; i++) t_r[i] <= t_v[i];
          step_r <= 4'd12;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            att_r[comp_r] <= t_cur[31] ? -q_ext : q_ext;
            comp_r        <= comp_r + 2'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_r.out_s      <= att_r[0];
            out_data_r.out_x      <= att_r[1];
            out_data_r.out_y      <= att_r[2];
            out_data_r.out_z      <= att_r[3];
            out_data_r.degenerate <= degen_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.out_s == ONE && out_data.out_x == 0 &&
      out_data.out_y == 0 && out_data.out_z == 0)
    else $error("degenerate result is not the identity");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> root != 32'd0)
    else $error("square root of a nonzero norm came out zero");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> q_ext <= ONE)
    else $error("normalized component exceeds one");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("accepted a beat without going busy");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_quaternion_attitude_integrator.sv
// testbench for the quaternion attitude integrator: directed table, random beats, predictor
module tb_quaternion_attitude_integrator;
  timeunit 1ns;
  timeprecision 1ps;
  import qai_pkg::*;

  localparam int FB = 30;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1600;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FB;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qai_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qai_out_t out_data;

  quaternion_attitude_integrator #(.FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted attitude
  logic signed [63:0] att_s, att_x, att_y, att_z;
  qai_out_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int rotates_sent = 0;
  int degenerates_seen = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 0;

  function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic signed [63:0] quarter_prod(logic signed [63:0] a,
                                                      logic signed [63:0] b);
    return floor_shr(a * b, 2);
  endfunction

  function automatic logic signed [63:0] round_incr(logic signed [63:0] sum);
    return floor_shr(sum + (64'sd1 <<< (FB - 2)), FB - 1);
  endfunction

  function automatic logic signed [63:0] clamp_sym(logic signed [63:0] v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < -SAT_MAX) return -SAT_MAX;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] unit_scale(logic signed [63:0] t, logic [63:0] r);
    logic [63:0] q;
    q = ((abs64(t) << FB) + (r >> 1)) / r;
    return t < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic qai_out_t integrate_attitude(qai_in_t b);
    qai_out_t res;
    logic signed [63:0] wx, wy, wz, s, x, y, z, ds, dx, dy, dz, ts, tx, ty, tz;
    logic [63:0] n, r;
    res.degenerate = 1'b0;
    if (b.command == CMD_LOAD) begin
      att_s = b.load_s; att_x = b.load_x; att_y = b.load_y; att_z = b.load_z;
    end else begin
      wx = b.incr_x; wy = b.incr_y; wz = b.incr_z;
      s = att_s; x = att_x; y = att_y; z = att_z;
      dx = round_incr(quarter_prod(s, wx) - quarter_prod(y, wz) + quarter_prod(z, wy));
      dy = round_incr(quarter_prod(s, wy) - quarter_prod(z, wx) + quarter_prod(x, wz));
      dz = round_incr(quarter_prod(s, wz) - quarter_prod(x, wy) + quarter_prod(y, wx));
      ds = round_incr(-(quarter_prod(x, wx) + quarter_prod(y, wy) + quarter_prod(z, wz)));
      ts = clamp_sym(s + ds); tx = clamp_sym(x + dx);
      ty = clamp_sym(y + dy); tz = clamp_sym(z + dz);
      n = abs64(ts) * abs64(ts) + abs64(tx) * abs64(tx) + abs64(ty) * abs64(ty)
          + abs64(tz) * abs64(tz);
      if (n == 0) begin
        att_s = ONE; att_x = 0; att_y = 0; att_z = 0;
        res.degenerate = 1'b1;
      end else begin
        r = int_sqrt(n);
        att_s = unit_scale(ts, r); att_x = unit_scale(tx, r);
        att_y = unit_scale(ty, r); att_z = unit_scale(tz, r);
      end
    end
    res.out_s = att_s[31:0]; res.out_x = att_x[31:0];
    res.out_y = att_y[31:0]; res.out_z = att_z[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // result side: stall and check
  always @(posedge clk) begin
    qai_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.degenerate) degenerates_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.out_s, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.out_s !== want.out_s) report_mismatch("out_s", out_data.out_s, want.out_s);
        if (out_data.out_x !== want.out_x) report_mismatch("out_x", out_data.out_x, want.out_x);
        if (out_data.out_y !== want.out_y) report_mismatch("out_y", out_data.out_y, want.out_y);
        if (out_data.out_z !== want.out_z) report_mismatch("out_z", out_data.out_z, want.out_z);
        if (out_data.degenerate !== want.degenerate)
          report_mismatch("degenerate", out_data.degenerate, want.degenerate);
      end
    end
  end

  always @(negedge clk)
    out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);

  // long receiver hold-off, counted here
  task automatic hold_receiver(int cycles);
    hold_recv = 1;
    repeat (cycles) @(negedge clk);
    hold_recv = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // offer one beat, wait for acceptance, predict; valid stays up for the caller
  task automatic send_beat(qai_in_t b, bit has_want = 0, qai_out_t want = '0);
    qai_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = integrate_attitude(b);
    if (has_want && pred !== want)
      report_mismatch("table row vs predictor", 64'(pred.out_s), 64'(want.out_s));
    expected_q.push_back(pred);
    if (b.command == CMD_ROTATE) rotates_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      default: return $signed($urandom_range(2 * (1 << FB))) - (1 <<< FB);
    endcase
  endfunction

  function automatic qai_in_t random_beat();
    qai_in_t b;
    int sel;
    sel = $urandom_range(99);
    b.command = (sel < 80) ? CMD_ROTATE : CMD_LOAD;
    b.load_s = rand_word(); b.load_x = rand_word();
    b.load_y = rand_word(); b.load_z = rand_word();
    if (sel < 60) begin
      // small gyro increments, the normal case
      b.incr_x = $signed($urandom_range(1 << 22)) - (1 <<< 21);
      b.incr_y = $signed($urandom_range(1 << 22)) - (1 <<< 21);
      b.incr_z = $signed($urandom_range(1 << 22)) - (1 <<< 21);
    end else begin
      b.incr_x = rand_word(); b.incr_y = rand_word(); b.incr_z = rand_word();
    end
    if (sel >= 97) begin
      // load a zero quaternion: a following rotate is degenerate
      b.command = CMD_LOAD;
      b.load_s = 0; b.load_x = 0; b.load_y = 0; b.load_z = 0;
    end
    return b;
  endfunction

  typedef struct {
    qai_in_t beat;
    bit has_want;
    qai_out_t want;
  } stim_row_t;

  stim_row_t stim_table[$];

  function automatic qai_in_t mk(logic cmd, logic signed [31:0] ix, logic signed [31:0] iy,
                                 logic signed [31:0] iz, logic signed [31:0] ls,
                                 logic signed [31:0] lx, logic signed [31:0] ly,
                                 logic signed [31:0] lz);
    qai_in_t b;
    b.command = cmd; b.incr_x = ix; b.incr_y = iy; b.incr_z = iz;
    b.load_s = ls; b.load_x = lx; b.load_y = ly; b.load_z = lz;
    return b;
  endfunction

  task automatic add_row(qai_in_t b, bit hw = 0, qai_out_t w = '0);
    stim_row_t r;
    r.beat = b; r.has_want = hw; r.want = w;
    stim_table.push_back(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  localparam logic signed [31:0] MIN_W = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_W = 32'sh7fff_ffff;

  initial begin
    int phase;
    att_s = ONE; att_x = 0; att_y = 0; att_z = 0;
    // identity after reset, zero increment keeps it
    add_row(mk(CMD_ROTATE, 0, 0, 0, 0, 0, 0, 0), 1, '{ONE, 0, 0, 0, 1'b0});
    add_row(mk(CMD_ROTATE, 32'sh0010_0000, 0, 0, 0, 0, 0, 0));
    add_row(mk(CMD_ROTATE, 0, 32'sh0010_0000, 0, 0, 0, 0, 0));
    add_row(mk(CMD_ROTATE, 0, 0, -32'sh0010_0000, 0, 0, 0, 0));
    // load stores as given, extremes included
    add_row(mk(CMD_LOAD, MAX_W, MIN_W, MAX_W, MIN_W, MAX_W, MIN_W, MAX_W),
            1, '{MIN_W, MAX_W, MIN_W, MAX_W, 1'b0});
    add_row(mk(CMD_ROTATE, MAX_W, MAX_W, MAX_W, 0, 0, 0, 0));
    add_row(mk(CMD_LOAD, 0, 0, 0, MAX_W, MAX_W, MAX_W, MAX_W),
            1, '{MAX_W, MAX_W, MAX_W, MAX_W, 1'b0});
    // saturating sum
    add_row(mk(CMD_ROTATE, MAX_W, MAX_W, MAX_W, 0, 0, 0, 0));
    add_row(mk(CMD_LOAD, 0, 0, 0, MIN_W, MIN_W, MIN_W, MIN_W),
            1, '{MIN_W, MIN_W, MIN_W, MIN_W, 1'b0});
    add_row(mk(CMD_ROTATE, MIN_W, MIN_W, MIN_W, 0, 0, 0, 0));
    // zero norm gives identity with degenerate
    add_row(mk(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 1'b0});
    add_row(mk(CMD_ROTATE, MAX_W, MIN_W, 5, 0, 0, 0, 0), 1, '{ONE, 0, 0, 0, 1'b1});
    // unnormalised tiny quaternion
    add_row(mk(CMD_LOAD, 0, 0, 0, 1, -1, 0, 0));
    add_row(mk(CMD_ROTATE, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(CMD_LOAD, 0, 0, 0, 0, 0, 0, -1));
    add_row(mk(CMD_ROTATE, MIN_W, MAX_W, MIN_W, 0, 0, 0, 0));
    add_row(mk(CMD_ROTATE, 32'sh4000_0000, -32'sh4000_0000, 32'sh2000_0000, 0, 0, 0, 0));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_table[i]) send_beat(stim_table[i].beat, stim_table[i].has_want,
                                      stim_table[i].want);
    drain();

    // receiver holds off while beats keep coming
    fork
      hold_receiver(3000);
      begin
        repeat (8) send_beat(random_beat());
        in_valid <= 1'b0;
      end
    join
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      repeat (N_RANDOM / 4) send_beat(random_beat());
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();

    $display("covered %0d results, %0d rotate beats, %0d degenerate norms", results_seen,
             rotates_sent, degenerates_seen);
    $display("phases: no idling, sender gaps, receiver stalls, both, and a long hold-off");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/qai_pkg.sv
rtl/core/qai_mul.sv
rtl/core/qai_sqrt.sv
rtl/core/qai_div.sv
rtl/core/quaternion_attitude_integrator.sv
tb/sv/tb_quaternion_attitude_integrator.sv
